[sv/abc_pkg.sv]
// Shared types and constants for the alpha bounds and centroid unit.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package abc_pkg;

  localparam int COORD_W    = 11;
  localparam int ALPHA_W    = 8;
  localparam int PROD_W     = COORD_W + ALPHA_W;
  localparam int WSUM_W     = 42;
  localparam int ASUM_W     = 31;
  localparam int FRAC_W     = 4;
  localparam int CENT_W     = 15;
  localparam int DIVD_W     = WSUM_W + FRAC_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Pixels with a coordinate at or beyond this edge never count.
  localparam int MAX_EDGE = 2048;
  localparam int EDGE_W   = COORD_W + 2;
  localparam logic [EDGE_W-1:0] MAX_EDGE_V = EDGE_W'(MAX_EDGE);

  localparam int QUEUE_DEPTH = 4;

  localparam logic [ALPHA_W-1:0] THR_RESET    = 8'd8;
  localparam logic [COORD_W-1:0] WIN_LO_RESET = '0;
  localparam logic [COORD_W-1:0] WIN_HI_RESET = '1;
  localparam logic [CENT_W-1:0]  CENT_MAX     = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA_THR  = 3'd0,
    CFG_WIN_LEFT   = 3'd1,
    CFG_WIN_TOP    = 3'd2,
    CFG_WIN_RIGHT  = 3'd3,
    CFG_WIN_BOTTOM = 3'd4
  } abc_cfg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] pix_x;
    logic [COORD_W-1:0] pix_y;
    logic [ALPHA_W-1:0] pix_alpha;
    logic               frame_end;
  } abc_pix_t;

  typedef struct packed {
    logic               is_empty;
    logic [COORD_W-1:0] box_left;
    logic [COORD_W-1:0] box_top;
    logic [COORD_W-1:0] box_right;
    logic [COORD_W-1:0] box_bottom;
    logic [CENT_W-1:0]  centroid_x;
    logic [CENT_W-1:0]  centroid_y;
  } abc_res_t;

  // Classified pixel as it travels from the front end to the back end.
  typedef struct packed {
    logic               hit;
    logic               last;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [ALPHA_W-1:0] alpha;
    logic [PROD_W-1:0]  wx;
    logic [PROD_W-1:0]  wy;
  } abc_qent_t;

  typedef enum logic [2:0] {
    BK_ACCUM,
    BK_X_GO,
    BK_X_WAIT,
    BK_Y_GO,
    BK_Y_WAIT,
    BK_EMIT
  } abc_bk_state_t;

  typedef struct packed {
    logic finishing;
    logic emit;
  } abc_bk_stat_t;

endpackage

`default_nettype wire

[sv/abc_front.sv]
// Front end: configuration registers and per-pixel classification.
// Depends on abc_pkg.
`default_nettype none

module abc_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [abc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [abc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire abc_pkg::abc_pix_t                   pix,
  output abc_pkg::abc_qent_t                       ent
);

  logic [abc_pkg::ALPHA_W-1:0] thr_r, thr_nxt;
  logic [abc_pkg::COORD_W-1:0] left_r, left_nxt;
  logic [abc_pkg::COORD_W-1:0] top_r, top_nxt;
  logic [abc_pkg::COORD_W-1:0] right_r, right_nxt;
  logic [abc_pkg::COORD_W-1:0] bottom_r, bottom_nxt;
  logic                        in_win;

  always_comb begin
    thr_nxt    = thr_r;
    left_nxt   = left_r;
    top_nxt    = top_r;
    right_nxt  = right_r;
    bottom_nxt = bottom_r;
    if (cfg_we) begin
      unique case (cfg_index)
        abc_pkg::CFG_ALPHA_THR:  thr_nxt    = cfg_data[abc_pkg::ALPHA_W-1:0];
        abc_pkg::CFG_WIN_LEFT:   left_nxt   = cfg_data[abc_pkg::COORD_W-1:0];
        abc_pkg::CFG_WIN_TOP:    top_nxt    = cfg_data[abc_pkg::COORD_W-1:0];
        abc_pkg::CFG_WIN_RIGHT:  right_nxt  = cfg_data[abc_pkg::COORD_W-1:0];
        abc_pkg::CFG_WIN_BOTTOM: bottom_nxt = cfg_data[abc_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= abc_pkg::THR_RESET;
      left_r   <= abc_pkg::WIN_LO_RESET;
      top_r    <= abc_pkg::WIN_LO_RESET;
      right_r  <= abc_pkg::WIN_HI_RESET;
      bottom_r <= abc_pkg::WIN_HI_RESET;
    end else begin
      thr_r    <= thr_nxt;
      left_r   <= left_nxt;
      top_r    <= top_nxt;
      right_r  <= right_nxt;
      bottom_r <= bottom_nxt;
    end
  end

  // An inverted window fails one of the two range checks on its own.
  assign in_win = (pix.pix_x >= left_r) && (pix.pix_x <= right_r) &&
                  (pix.pix_y >= top_r) && (pix.pix_y <= bottom_r) &&
                  ({2'b00, pix.pix_x} < abc_pkg::MAX_EDGE_V) &&
                  ({2'b00, pix.pix_y} < abc_pkg::MAX_EDGE_V);

  always_comb begin
    ent.hit   = in_win && (pix.pix_alpha > thr_r);
    ent.last  = pix.frame_end;
    ent.x     = pix.pix_x;
    ent.y     = pix.pix_y;
    ent.alpha = pix.pix_alpha;
    ent.wx    = abc_pkg::PROD_W'(pix.pix_x) * abc_pkg::PROD_W'(pix.pix_alpha);
    ent.wy    = abc_pkg::PROD_W'(pix.pix_y) * abc_pkg::PROD_W'(pix.pix_alpha);
  end

endmodule

`default_nettype wire

[sv/abc_queue.sv]
// Short first-word-fall-through queue between the front and back ends.
// Depends on abc_pkg for the entry type.
`default_nettype none

module abc_queue #(
  parameter int DEPTH = abc_pkg::QUEUE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             push_valid,
  output logic                                  push_ready,
  input  wire abc_pkg::abc_qent_t               push_data,
  output logic                                  pop_valid,
  input  wire logic                             pop_ready,
  output abc_pkg::abc_qent_t                    pop_data,
  output logic [$clog2(DEPTH+1)-1:0]            level
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  abc_pkg::abc_qent_t mem_r [DEPTH];
  logic [AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign push_ready = (cnt_r != FULL_CNT);
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];
  assign level      = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[sv/abc_div.sv]
// Iterative restoring divider for the centroid: one quotient bit per cycle,
// with zero-divisor and saturation tests up front. Depends on abc_pkg.
`default_nettype none

module abc_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [abc_pkg::DIVD_W-1:0]     dividend,
  input  wire logic [abc_pkg::ASUM_W-1:0]     divisor,
  output logic                                done,
  output logic [abc_pkg::CENT_W-1:0]          quotient
);

  localparam int CW = $clog2(abc_pkg::CENT_W + 1);
  localparam int HI = abc_pkg::DIVD_W - abc_pkg::CENT_W;

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [abc_pkg::ASUM_W-1:0]    rem_r, rem_nxt;
  logic [abc_pkg::ASUM_W-1:0]    dvs_r, dvs_nxt;
  logic [abc_pkg::CENT_W-1:0]    low_r, low_nxt;
  logic [abc_pkg::CENT_W-1:0]    quo_r, quo_nxt;
  logic [abc_pkg::ASUM_W:0]      trial;
  logic [abc_pkg::ASUM_W:0]      diff;
  logic                          fits;

  assign trial = {rem_r, low_r[abc_pkg::CENT_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    if (start) begin
      // A quotient that cannot fit in the result width shows already in the
      // high part of the dividend: it saturates without iterating.
      if (divisor == '0) begin
        quo_nxt  = '0;
        done_nxt = 1'b1;
      end else if (dividend[abc_pkg::DIVD_W-1:abc_pkg::CENT_W] >= HI'(divisor)) begin
        quo_nxt  = abc_pkg::CENT_MAX;
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        cnt_nxt  = CW'(abc_pkg::CENT_W);
        rem_nxt  = dividend[abc_pkg::DIVD_W-1:abc_pkg::CENT_W];
        low_nxt  = dividend[abc_pkg::CENT_W-1:0];
        dvs_nxt  = divisor;
        quo_nxt  = '0;
      end
    end else if (busy_r) begin
      rem_nxt = fits ? diff[abc_pkg::ASUM_W-1:0] : trial[abc_pkg::ASUM_W-1:0];
      quo_nxt = {quo_r[abc_pkg::CENT_W-2:0], fits};
      low_nxt = {low_r[abc_pkg::CENT_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

[sv/abc_back.sv]
// Back end: frame accumulators, end-of-frame sequencer and result register.
// Depends on abc_pkg; drives the shared divider abc_div.
`default_nettype none

module abc_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_valid,
  output logic                                q_ready,
  input  wire abc_pkg::abc_qent_t             q_data,
  output logic                                div_start,
  output logic [abc_pkg::DIVD_W-1:0]          div_dividend,
  output logic [abc_pkg::ASUM_W-1:0]          div_divisor,
  input  wire logic                           div_done,
  input  wire logic [abc_pkg::CENT_W-1:0]     div_quot,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output abc_pkg::abc_res_t                   out_data,
  output abc_pkg::abc_bk_stat_t               stat
);

  abc_pkg::abc_bk_state_t      state_r, state_nxt;
  logic [abc_pkg::COORD_W-1:0] min_col_r, min_col_nxt;
  logic [abc_pkg::COORD_W-1:0] min_row_r, min_row_nxt;
  logic [abc_pkg::COORD_W-1:0] max_col_r, max_col_nxt;
  logic [abc_pkg::COORD_W-1:0] max_row_r, max_row_nxt;
  logic                        any_hit_r, any_hit_nxt;
  logic [abc_pkg::WSUM_W-1:0]  sum_wx_r, sum_wx_nxt;
  logic [abc_pkg::WSUM_W-1:0]  sum_wy_r, sum_wy_nxt;
  logic [abc_pkg::ASUM_W-1:0]  sum_w_r, sum_w_nxt;
  logic [abc_pkg::CENT_W-1:0]  cent_x_r, cent_x_nxt;
  logic                        out_valid_r, out_valid_nxt;
  abc_pkg::abc_res_t           out_data_r, out_data_nxt;

  assign q_ready      = (state_r == abc_pkg::BK_ACCUM);
  assign div_dividend = (state_r == abc_pkg::BK_Y_GO) ? {sum_wy_r, {abc_pkg::FRAC_W{1'b0}}}
                                                      : {sum_wx_r, {abc_pkg::FRAC_W{1'b0}}};
  assign div_divisor  = sum_w_r;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    min_col_nxt   = min_col_r;
    min_row_nxt   = min_row_r;
    max_col_nxt   = max_col_r;
    max_row_nxt   = max_row_r;
    any_hit_nxt   = any_hit_r;
    sum_wx_nxt    = sum_wx_r;
    sum_wy_nxt    = sum_wy_r;
    sum_w_nxt     = sum_w_r;
    cent_x_nxt    = cent_x_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    stat.finishing = 1'b0;
    stat.emit      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      abc_pkg::BK_ACCUM: begin
        if (q_valid) begin
          if (q_data.hit) begin
            if (q_data.x < min_col_r) min_col_nxt = q_data.x;
            if (q_data.y < min_row_r) min_row_nxt = q_data.y;
            if (q_data.x > max_col_r) max_col_nxt = q_data.x;
            if (q_data.y > max_row_r) max_row_nxt = q_data.y;
            any_hit_nxt = 1'b1;
            sum_wx_nxt  = sum_wx_r + abc_pkg::WSUM_W'(q_data.wx);
            sum_wy_nxt  = sum_wy_r + abc_pkg::WSUM_W'(q_data.wy);
            sum_w_nxt   = sum_w_r + abc_pkg::ASUM_W'(q_data.alpha);
          end
          if (q_data.last) begin
            state_nxt = abc_pkg::BK_X_GO;
          end
        end
      end
      abc_pkg::BK_X_GO: begin
        stat.finishing = 1'b1;
        div_start      = 1'b1;
        state_nxt      = abc_pkg::BK_X_WAIT;
      end
      abc_pkg::BK_X_WAIT: begin
        stat.finishing = 1'b1;
        if (div_done) begin
          cent_x_nxt = div_quot;
          state_nxt  = abc_pkg::BK_Y_GO;
        end
      end
      abc_pkg::BK_Y_GO: begin
        stat.finishing = 1'b1;
        div_start      = 1'b1;
        state_nxt      = abc_pkg::BK_Y_WAIT;
      end
      abc_pkg::BK_Y_WAIT: begin
        stat.finishing = 1'b1;
        if (div_done) begin
          state_nxt = abc_pkg::BK_EMIT;
        end
      end
      abc_pkg::BK_EMIT: begin
        stat.emit = 1'b1;
        // The divider holds the y quotient until its next start.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (any_hit_r) begin
            out_data_nxt.is_empty   = 1'b0;
            out_data_nxt.box_left   = min_col_r;
            out_data_nxt.box_top    = min_row_r;
            out_data_nxt.box_right  = max_col_r;
            out_data_nxt.box_bottom = max_row_r;
            out_data_nxt.centroid_x = cent_x_r;
            out_data_nxt.centroid_y = div_quot;
          end else begin
            out_data_nxt          = '0;
            out_data_nxt.is_empty = 1'b1;
          end
          min_col_nxt = '1;
          min_row_nxt = '1;
          max_col_nxt = '0;
          max_row_nxt = '0;
          any_hit_nxt = 1'b0;
          sum_wx_nxt  = '0;
          sum_wy_nxt  = '0;
          sum_w_nxt   = '0;
          state_nxt   = abc_pkg::BK_ACCUM;
        end
      end
      default: begin
        state_nxt = abc_pkg::BK_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= abc_pkg::BK_ACCUM;
      min_col_r   <= '1;
      min_row_r   <= '1;
      max_col_r   <= '0;
      max_row_r   <= '0;
      any_hit_r   <= 1'b0;
      sum_wx_r    <= '0;
      sum_wy_r    <= '0;
      sum_w_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      min_col_r   <= min_col_nxt;
      min_row_r   <= min_row_nxt;
      max_col_r   <= max_col_nxt;
      max_row_r   <= max_row_nxt;
      any_hit_r   <= any_hit_nxt;
      sum_wx_r    <= sum_wx_nxt;
      sum_wy_r    <= sum_wy_nxt;
      sum_w_r     <= sum_w_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cent_x_r   <= cent_x_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

[sv/alpha_bounds_centroid_unit.sv]
// Top level of the alpha bounds and centroid unit.
// Depends on abc_pkg, abc_front, abc_queue, abc_div and abc_back.
//
// Takes a raster stream of pixels, one per cycle, and per frame reports the
// bounding box of the pixels that lie inside the scan window and whose alpha
// exceeds the threshold, plus their alpha-weighted centroid with four
// fractional bits (truncated, saturating at the top of the 15-bit range).
// The front end classifies each pixel and multiplies its coordinates by its
// alpha as it is accepted; a small queue then feeds the back end, which adds
// one pixel per cycle into the frame sums. On the frame's last pixel the back
// end stops draining the queue and runs both centroids through one shared
// bit-serial divider, x then y, then loads the result; while a frame end
// holds the back end, the front end accepts pixels until the queue is full.
// The result sits in an output register and the next frame proceeds while it
// waits to be taken. Configuration writes are always accepted and take
// effect on the next pixel; they are meant for idle periods between streams.
`default_nettype none

module alpha_bounds_centroid_unit #(
  parameter int QUEUE_DEPTH = abc_pkg::QUEUE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire abc_pkg::abc_pix_t                in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output abc_pkg::abc_res_t                     out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [abc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [abc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int LW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [LW-1:0] FULL_LEVEL = LW'(QUEUE_DEPTH);

  abc_pkg::abc_qent_t    fe_ent;
  abc_pkg::abc_qent_t    q_data;
  logic                  q_valid;
  logic                  q_ready;
  logic [LW-1:0]         q_level;
  logic                  div_start;
  logic [abc_pkg::DIVD_W-1:0] div_dividend;
  logic [abc_pkg::ASUM_W-1:0] div_divisor;
  logic                  div_done;
  logic [abc_pkg::CENT_W-1:0] div_quot;
  abc_pkg::abc_bk_stat_t bk_stat;

  assign cfg_ready = 1'b1;

  abc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (in_data),
    .ent       (fe_ent)
  );

  abc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (fe_ent),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data),
    .level      (q_level)
  );

  abc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  abc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_data       (q_data),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quot     (div_quot),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .stat         (bk_stat)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= FULL_LEVEL)
    else $error("queue level exceeds its depth");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (q_level == FULL_LEVEL) |-> !in_ready)
    else $error("pixel accepted into a full queue");

  a_no_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_stat.finishing || bk_stat.emit) |-> !q_ready)
    else $error("queue drained while a frame result is being formed");

  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(bk_stat.emit))
    else $error("result appeared without an emit step");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for alpha_bounds_centroid_unit.
// Depends on abc_pkg and the unit's RTL. A directed table runs first, then random frames
// under several window and threshold settings, checked against an in-bench predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int COORD_MAX       = (1 << abc_pkg::COORD_W) - 1;
  localparam int ALPHA_MAX       = (1 << abc_pkg::ALPHA_W) - 1;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 52;
  localparam int BURST_LEN       = 24;
  localparam int HOLD_CYCLES     = 200;
  localparam int DRAIN_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    abc_pkg::abc_pix_t pix;
    logic              typed;
    abc_pkg::abc_res_t res;
  } dir_row_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  abc_pkg::abc_pix_t              in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  abc_pkg::abc_res_t              out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [abc_pkg::CFG_IDX_W-1:0]  cfg_index = abc_pkg::CFG_ALPHA_THR;
  logic [abc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // Register copies and frame accumulators of the predictor.
  logic [abc_pkg::ALPHA_W-1:0] thr_cfg;
  logic [abc_pkg::COORD_W-1:0] wl_cfg, wt_cfg, wr_cfg, wb_cfg;
  logic [abc_pkg::COORD_W-1:0] lo_x, lo_y, hi_x, hi_y;
  bit                          seen_hit;
  logic [abc_pkg::WSUM_W-1:0]  wsum_x, wsum_y;
  logic [abc_pkg::ASUM_W-1:0]  wsum_a;

  abc_pkg::abc_res_t frame_q[$];
  dir_row_t          rows[$];

  bit no_idle  = 1'b0;
  bit hold_req = 1'b0;
  int quiet    = 0;
  int n_fail   = 0;
  int n_items  = 0;
  int n_frames = 0;
  int n_empty  = 0;
  int n_cfg    = 0;
  int n_holds  = 0;

  always #5 clk = ~clk;

  alpha_bounds_centroid_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  task automatic restart_frame();
    lo_x     = '1;
    lo_y     = '1;
    hi_x     = '0;
    hi_y     = '0;
    seen_hit = 1'b0;
    wsum_x   = '0;
    wsum_y   = '0;
    wsum_a   = '0;
  endtask

  function automatic logic [abc_pkg::CENT_W-1:0] weighted_mean(
      logic [abc_pkg::WSUM_W-1:0] wsum, logic [abc_pkg::ASUM_W-1:0] total);
    logic [abc_pkg::DIVD_W-1:0] q;
    if (total == '0) return '0;
    q = (abc_pkg::DIVD_W'(wsum) << abc_pkg::FRAC_W) / abc_pkg::DIVD_W'(total);
    return (q > abc_pkg::DIVD_W'(abc_pkg::CENT_MAX)) ? abc_pkg::CENT_MAX
                                                      : q[abc_pkg::CENT_W-1:0];
  endfunction

  // Folds one pixel into the frame sums; on the frame's last pixel it forms the result.
  task automatic predict_pixel(input abc_pkg::abc_pix_t p, output bit has_res,
                               output abc_pkg::abc_res_t r);
    bit counts;
    counts = p.pix_x >= wl_cfg && p.pix_x <= wr_cfg &&
             p.pix_y >= wt_cfg && p.pix_y <= wb_cfg &&
             int'(p.pix_x) < abc_pkg::MAX_EDGE && int'(p.pix_y) < abc_pkg::MAX_EDGE &&
             p.pix_alpha > thr_cfg;
    if (counts) begin
      if (p.pix_x < lo_x) lo_x = p.pix_x;
      if (p.pix_y < lo_y) lo_y = p.pix_y;
      if (p.pix_x > hi_x) hi_x = p.pix_x;
      if (p.pix_y > hi_y) hi_y = p.pix_y;
      seen_hit = 1'b1;
      wsum_x = wsum_x + abc_pkg::WSUM_W'(p.pix_x) * abc_pkg::WSUM_W'(p.pix_alpha);
      wsum_y = wsum_y + abc_pkg::WSUM_W'(p.pix_y) * abc_pkg::WSUM_W'(p.pix_alpha);
      wsum_a = wsum_a + abc_pkg::ASUM_W'(p.pix_alpha);
    end
    has_res = p.frame_end;
    r = '0;
    if (has_res) begin
      if (seen_hit) begin
        r.box_left   = lo_x;
        r.box_top    = lo_y;
        r.box_right  = hi_x;
        r.box_bottom = hi_y;
        r.centroid_x = weighted_mean(wsum_x, wsum_a);
        r.centroid_y = weighted_mean(wsum_y, wsum_a);
      end else begin
        r.is_empty = 1'b1;
      end
      restart_frame();
    end
  endtask

  function automatic abc_pkg::abc_res_t make_res(bit empty, int l, int t, int rt, int b,
                                                 int cx, int cy);
    abc_pkg::abc_res_t r;
    r.is_empty   = empty;
    r.box_left   = abc_pkg::COORD_W'(l);
    r.box_top    = abc_pkg::COORD_W'(t);
    r.box_right  = abc_pkg::COORD_W'(rt);
    r.box_bottom = abc_pkg::COORD_W'(b);
    r.centroid_x = abc_pkg::CENT_W'(cx);
    r.centroid_y = abc_pkg::CENT_W'(cy);
    return r;
  endfunction

  function automatic abc_pkg::abc_pix_t make_pix(int x, int y, int a, bit last);
    abc_pkg::abc_pix_t p;
    p.pix_x     = abc_pkg::COORD_W'(x);
    p.pix_y     = abc_pkg::COORD_W'(y);
    p.pix_alpha = abc_pkg::ALPHA_W'(a);
    p.frame_end = last;
    return p;
  endfunction

  task automatic add_row(int x, int y, int a, bit last);
    dir_row_t d;
    d.pix   = make_pix(x, y, a, last);
    d.typed = 1'b0;
    d.res   = '0;
    rows.push_back(d);
  endtask

  task automatic add_checked(int x, int y, int a, abc_pkg::abc_res_t res);
    dir_row_t d;
    d.pix   = make_pix(x, y, a, 1'b1);
    d.typed = 1'b1;
    d.res   = res;
    rows.push_back(d);
  endtask

  // Coordinates mostly land in or just around the window spanned by a and b.
  function automatic logic [abc_pkg::COORD_W-1:0] pick_coord(
      logic [abc_pkg::COORD_W-1:0] a, logic [abc_pkg::COORD_W-1:0] b);
    int lo, hi, k;
    lo = (a < b) ? int'(a) : int'(b);
    hi = (a < b) ? int'(b) : int'(a);
    lo = (lo >= 2) ? lo - 2 : 0;
    hi = (hi <= COORD_MAX - 2) ? hi + 2 : COORD_MAX;
    k  = $urandom_range(9, 0);
    if (k < 7) return abc_pkg::COORD_W'($urandom_range(hi, lo));
    if (k == 7) return ($urandom_range(1, 0) != 0) ? abc_pkg::COORD_W'(COORD_MAX) : '0;
    return abc_pkg::COORD_W'($urandom_range(COORD_MAX, 0));
  endfunction

  function automatic abc_pkg::abc_pix_t rand_pixel();
    abc_pkg::abc_pix_t p;
    int k, a;
    p.pix_x = pick_coord(wl_cfg, wr_cfg);
    p.pix_y = pick_coord(wt_cfg, wb_cfg);
    k = $urandom_range(9, 0);
    unique case (k)
      0: a = 0;
      1: a = ALPHA_MAX;
      2, 3, 4: begin
        a = int'(thr_cfg) - 1 + int'($urandom_range(2, 0));
        if (a < 0) a = 0;
        if (a > ALPHA_MAX) a = ALPHA_MAX;
      end
      default: a = $urandom_range(ALPHA_MAX, 0);
    endcase
    p.pix_alpha = abc_pkg::ALPHA_W'(a);
    p.frame_end = ($urandom_range(7, 0) == 0);
    return p;
  endfunction

  task automatic send_pix(abc_pkg::abc_pix_t p, bit typed, abc_pkg::abc_res_t typed_res);
    int gap;
    bit has_res;
    abc_pkg::abc_res_t r;
    gap = no_idle ? 0 : $urandom_range(5, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
    predict_pixel(p, has_res, r);
    if (has_res) frame_q.push_back(typed ? typed_res : r);
  endtask

  task automatic write_reg(logic [abc_pkg::CFG_IDX_W-1:0] idx,
                           logic [abc_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    n_cfg++;
    unique case (idx)
      abc_pkg::CFG_ALPHA_THR:  thr_cfg = val[abc_pkg::ALPHA_W-1:0];
      abc_pkg::CFG_WIN_LEFT:   wl_cfg  = val[abc_pkg::COORD_W-1:0];
      abc_pkg::CFG_WIN_TOP:    wt_cfg  = val[abc_pkg::COORD_W-1:0];
      abc_pkg::CFG_WIN_RIGHT:  wr_cfg  = val[abc_pkg::COORD_W-1:0];
      abc_pkg::CFG_WIN_BOTTOM: wb_cfg  = val[abc_pkg::COORD_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stops the sender, waits for every pending frame result, then lets the
  // back end finish any pixels still queued behind the last frame end.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               quiet, frame_q.size());
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : result_sink
    int stall;
    bit bad;
    abc_pkg::abc_res_t want;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
        n_holds++;
      end else begin
        stall = no_idle ? 0 : $urandom_range(5, 0);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      n_frames++;
      if (out_data.is_empty === 1'b1) n_empty++;
      if (frame_q.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS)
          $display("unexpected result: empty=%0b box=%0d,%0d,%0d,%0d cent=%0d,%0d",
                   out_data.is_empty, out_data.box_left, out_data.box_top,
                   out_data.box_right, out_data.box_bottom,
                   out_data.centroid_x, out_data.centroid_y);
      end else begin
        want = frame_q.pop_front();
        bad  = (out_data.is_empty   !== want.is_empty)   ||
               (out_data.box_left   !== want.box_left)   ||
               (out_data.box_top    !== want.box_top)    ||
               (out_data.box_right  !== want.box_right)  ||
               (out_data.box_bottom !== want.box_bottom) ||
               (out_data.centroid_x !== want.centroid_x) ||
               (out_data.centroid_y !== want.centroid_y);
        if (bad) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS) begin
            $display("mismatch on frame %0d: expected empty=%0b box=%0d,%0d,%0d,%0d cent=%0d,%0d",
                     n_frames, want.is_empty, want.box_left, want.box_top,
                     want.box_right, want.box_bottom, want.centroid_x, want.centroid_y);
            $display("  got empty=%0b box=%0d,%0d,%0d,%0d cent=%0d,%0d",
                     out_data.is_empty, out_data.box_left, out_data.box_top,
                     out_data.box_right, out_data.box_bottom,
                     out_data.centroid_x, out_data.centroid_y);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int l, t, r, b, th;
    abc_pkg::abc_pix_t p;

    thr_cfg = abc_pkg::THR_RESET;
    wl_cfg  = abc_pkg::WIN_LO_RESET;
    wt_cfg  = abc_pkg::WIN_LO_RESET;
    wr_cfg  = abc_pkg::WIN_HI_RESET;
    wb_cfg  = abc_pkg::WIN_HI_RESET;
    restart_frame();

    // Directed frames under the reset settings: threshold 8, full window.
    add_checked(5, 5, 0, make_res(1, 0, 0, 0, 0, 0, 0));
    add_checked(0, 0, 255, make_res(0, 0, 0, 0, 0, 0, 0));
    add_checked(2047, 2047, 255, make_res(0, 2047, 2047, 2047, 2047, 32752, 32752));
    add_checked(100, 200, 8, make_res(1, 0, 0, 0, 0, 0, 0));
    add_checked(1, 2, 9, make_res(0, 1, 2, 1, 2, 16, 32));
    add_row(0, 2047, 255, 1'b0);
    add_row(2047, 0, 255, 1'b0);
    add_row(1024, 1024, 1, 1'b0);
    add_row(10, 20, 200, 1'b1);
    // The last pixel falls below the threshold but still closes the frame.
    add_row(300, 400, 128, 1'b0);
    add_row(500, 600, 64, 1'b0);
    add_row(7, 7, 3, 1'b1);
    add_row(2047, 0, 255, 1'b0);
    add_checked(0, 2047, 255, make_res(0, 0, 0, 2047, 2047, 16376, 16376));
    add_row(1365, 682, 170, 1'b0);
    add_row(682, 1365, 85, 1'b1);
    add_row(3, 5, 9, 1'b0);
    add_row(3, 5, 9, 1'b0);
    add_row(9, 1, 255, 1'b0);
    add_row(4, 4, 0, 1'b1);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) send_pix(rows[i].pix, rows[i].typed, rows[i].res);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      th = $urandom_range(ALPHA_MAX, 0);
      l  = $urandom_range(COORD_MAX, 0);
      r  = $urandom_range(COORD_MAX, l);
      t  = $urandom_range(COORD_MAX, 0);
      b  = $urandom_range(COORD_MAX, t);
      unique case (ph)
        0: begin
          th = 0;
          l  = 0;
          t  = 0;
          r  = COORD_MAX;
          b  = COORD_MAX;
        end
        1: th = ALPHA_MAX;
        2: begin
          // Right edge left of the left edge: nothing can count.
          l = $urandom_range(COORD_MAX, 1);
          r = $urandom_range(l - 1, 0);
        end
        3: begin
          t = $urandom_range(COORD_MAX, 1);
          b = $urandom_range(t - 1, 0);
        end
        4: begin
          r = l;
          b = t;
        end
        5: begin
          l = $urandom_range(COORD_MAX - 31, 0);
          t = $urandom_range(COORD_MAX - 31, 0);
          r = l + 31;
          b = t + 31;
        end
        6: begin
          l = COORD_MAX;
          t = COORD_MAX;
          r = COORD_MAX;
          b = COORD_MAX;
        end
        default: begin
          l = 0;
          t = 0;
          r = COORD_MAX;
          b = COORD_MAX;
        end
      endcase
      // Upper data bits of a threshold write are random; only the low byte matters.
      write_reg(abc_pkg::CFG_ALPHA_THR,
                abc_pkg::CFG_DATA_W'(($urandom_range(7, 0) << abc_pkg::ALPHA_W) | th));
      write_reg(abc_pkg::CFG_WIN_LEFT, abc_pkg::CFG_DATA_W'(l));
      write_reg(abc_pkg::CFG_WIN_TOP, abc_pkg::CFG_DATA_W'(t));
      write_reg(abc_pkg::CFG_WIN_RIGHT, abc_pkg::CFG_DATA_W'(r));
      write_reg(abc_pkg::CFG_WIN_BOTTOM, abc_pkg::CFG_DATA_W'(b));
      write_reg(abc_pkg::CFG_IDX_W'($urandom_range((1 << abc_pkg::CFG_IDX_W) - 1,
                                                   int'(abc_pkg::CFG_WIN_BOTTOM) + 1)),
                abc_pkg::CFG_DATA_W'($urandom_range(COORD_MAX, 0)));

      no_idle = (ph % 3 == 2);
      if (ph == 3) begin
        // Back-to-back frame ends while the receiver holds off fill the unit.
        hold_req = 1'b1;
        repeat (BURST_LEN) begin
          p = rand_pixel();
          p.frame_end = 1'b1;
          send_pix(p, 1'b0, '0);
        end
      end
      repeat (ITEMS_PER_PHASE) send_pix(rand_pixel(), 1'b0, '0);
    end

    settle();
    $display("summary: %0d pixels over %0d settings, %0d frame results (%0d empty), %0d writes",
             n_items, NUM_PHASES + 1, n_frames, n_empty, n_cfg);
    $display("summary: %0d long receiver hold-off(s), %0d failures, %0d results left over",
             n_holds, n_fail, frame_q.size());
    if (n_fail == 0 && frame_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/abc_pkg.sv
sv/abc_front.sv
sv/abc_queue.sv
sv/abc_div.sv
sv/abc_back.sv
sv/alpha_bounds_centroid_unit.sv
tb/tb_top.sv
